/* sv/button_click_hold_detector_core_assert.svh */
// Assertion macros shared by the checker file of the button detector.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BCHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BCHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bchd_pkg.sv */
// Shared types and constants of the button click and hold detector.
`default_nettype none

package bchd_pkg;

  // Field widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CIDX_W  = 8;

  // Saturation value of the elapsed counters
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CLICK    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD     = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_HOLD     = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_INVERT   = 8'd2;
  localparam logic [CIDX_W-1:0] CFG_EDGE     = 8'd3;

  // Configuration reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TICK_W-1:0] HOLD_RST     = 16'd1000;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic              invert_level;
    logic              edge_arm_mode;
  } cfg_t;

  typedef struct packed {
    logic               click;
    logic               hold;
    logic [PHASE_W-1:0] phase;
  } result_t;

endpackage

`default_nettype wire

/* sv/bchd_cfg.sv */
// Configuration register file of the button detector.
`default_nettype none

module bchd_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [bchd_pkg::CIDX_W-1:0] wr_index,
  input  wire logic [bchd_pkg::TICK_W-1:0] wr_data,
  output bchd_pkg::cfg_t                   cfg
);

  bchd_pkg::cfg_t cfg_r;
  bchd_pkg::cfg_t cfg_nxt;

  // Decode one register write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        bchd_pkg::CFG_DEBOUNCE: cfg_nxt.debounce_ticks = wr_data;
        bchd_pkg::CFG_HOLD:     cfg_nxt.hold_ticks     = wr_data;
        bchd_pkg::CFG_INVERT:   cfg_nxt.invert_level   = wr_data[0];
        bchd_pkg::CFG_EDGE:     cfg_nxt.edge_arm_mode  = wr_data[0];
        default:                cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= bchd_pkg::DEBOUNCE_RST;
      cfg_r.hold_ticks     <= bchd_pkg::HOLD_RST;
      cfg_r.invert_level   <= 1'b0;
      cfg_r.edge_arm_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/bchd_fsm.sv */
// Phase state machine and elapsed counters; one tick per enable.
`default_nettype none

module bchd_fsm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tick_en,
  input  wire logic          pin,
  input  wire bchd_pkg::cfg_t cfg,
  output bchd_pkg::result_t  res
);

  logic [bchd_pkg::PHASE_W-1:0] phase_r;
  logic [bchd_pkg::PHASE_W-1:0] phase_nxt;
  logic [bchd_pkg::CNT_W-1:0]   since_press_r;
  logic [bchd_pkg::CNT_W-1:0]   since_press_nxt;
  logic [bchd_pkg::CNT_W-1:0]   since_release_r;
  logic [bchd_pkg::CNT_W-1:0]   since_release_nxt;
  logic                         prev_pin_r;
  logic                         click;
  logic                         hold;
  logic                         pressed;
  logic                         arm_cond;
  logic [bchd_pkg::CNT_W-1:0]   db_ext;
  logic [bchd_pkg::CNT_W-1:0]   hold_ext;

  assign db_ext   = {1'b0, cfg.debounce_ticks};
  assign hold_ext = {1'b0, cfg.hold_ticks};
  assign pressed  = pin ^ cfg.invert_level;
  assign arm_cond = cfg.edge_arm_mode ? (pin != prev_pin_r) : pressed;

  // One tick: count, then arm, click and hold checks in that order
  always_comb begin
    since_press_nxt   = (since_press_r == bchd_pkg::CNT_MAX) ? bchd_pkg::CNT_MAX
                                                             : since_press_r + 1'b1;
    since_release_nxt = (since_release_r == bchd_pkg::CNT_MAX) ? bchd_pkg::CNT_MAX
                                                                 : since_release_r + 1'b1;
    phase_nxt = phase_r;
    click     = 1'b0;
    hold      = 1'b0;

    // arm, only after the release lockout
    if (phase_nxt == bchd_pkg::PH_IDLE && arm_cond && since_release_nxt > db_ext) begin
      phase_nxt       = bchd_pkg::PH_DEBOUNCE;
      since_press_nxt = '0;
    end

    // debounce done, then short press release
    if (phase_nxt == bchd_pkg::PH_DEBOUNCE && since_press_nxt > db_ext) begin
      phase_nxt = bchd_pkg::PH_CLICK;
    end
    if (phase_nxt == bchd_pkg::PH_CLICK && !pressed) begin
      click             = 1'b1;
      since_release_nxt = '0;
      phase_nxt         = bchd_pkg::PH_IDLE;
    end

    // hold time reached, then long press release
    if (phase_nxt == bchd_pkg::PH_CLICK && since_press_nxt > hold_ext) begin
      phase_nxt = bchd_pkg::PH_HOLD;
    end
    if (phase_nxt == bchd_pkg::PH_HOLD && !pressed) begin
      hold              = 1'b1;
      since_release_nxt = '0;
      phase_nxt         = bchd_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= bchd_pkg::PH_IDLE;
      since_press_r   <= '0;
      since_release_r <= bchd_pkg::CNT_MAX;
      prev_pin_r      <= 1'b0;
    end else if (tick_en) begin
      phase_r         <= phase_nxt;
      since_press_r   <= since_press_nxt;
      since_release_r <= since_release_nxt;
      prev_pin_r      <= pin;
    end
  end

  assign res.click = click;
  assign res.hold  = hold;
  assign res.phase = phase_nxt;

endmodule

`default_nettype wire

/* sv/button_click_hold_detector_core.sv */
// Top level of the debounced button click and long press detector.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_pin_level
//   out     | output    | out_valid / out_ready | out_click, out_hold, out_phase
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each request passes an input register, then the tick logic writes the
// result register, from which the result is offered; one request per cycle while the result is not stalled.
// The phase and counter update is combinational logic, so ticks run back to back.
// A stalled result holds the input register; input stalls only when both are full.
// Reset (rst_n low, synchronous) empties both registers and loads register defaults.
`default_nettype none

module button_click_hold_detector_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               in_pin_level,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_click,
  output      logic                               out_hold,
  output      logic [bchd_pkg::PHASE_W-1:0]       out_phase,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [bchd_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [bchd_pkg::TICK_W-1:0]        cfg_data
);

  logic              in_valid_r;
  logic              in_pin_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  bchd_pkg::result_t out_res_r;
  bchd_pkg::result_t step_res;
  bchd_pkg::cfg_t    cfg;
  logic              out_load;
  logic              in_take;

  assign cfg_ready = 1'b1;

  bchd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline flow control
  assign out_load      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !in_valid_r || out_load;
  assign in_take       = in_valid && in_ready;
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take || (in_valid_r && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pin_r <= in_pin_level;
    end
  end

  bchd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (out_load),
    .pin     (in_pin_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_click = out_res_r.click;
  assign out_hold  = out_res_r.hold;
  assign out_phase = out_res_r.phase;

endmodule

`default_nettype wire

/* sv/bchd_chk.sv */
// Port-level checker of the button detector, bound to the top level.
`default_nettype none

`include "button_click_hold_detector_core_assert.svh"

module bchd_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_click,
  input wire logic                         out_hold,
  input wire logic [bchd_pkg::PHASE_W-1:0] out_phase
);

  // Stalled result stays offered and unchanged
  `BCHD_ASSERT_NXT(a_out_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `BCHD_ASSERT_NXT(a_out_hold_phase, out_valid && !out_ready, $stable(out_phase), "phase changed while stalled")

  // Click and hold never report together
  `BCHD_ASSERT_IMP(a_one_event, out_valid, !(out_click && out_hold), "click and hold together")

  // Any release event leaves the block idle
  `BCHD_ASSERT_IMP(a_event_idle, out_valid && (out_click || out_hold), out_phase == bchd_pkg::PH_IDLE, "event without return to idle")

endmodule

bind button_click_hold_detector_core bchd_chk u_bchd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_click (out_click),
  .out_hold  (out_hold),
  .out_phase (out_phase)
);

`default_nettype wire

/* tb/button_click_hold_detector_core_tb.sv */
// Self-checking testbench for the button click and hold detector core.
module button_click_hold_detector_core_tb;
  import bchd_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int MAX_IDLE        = 17;
  // Slowest request: longest gap plus longest stall plus the pipeline registers; leave wide margin
  localparam int QUIET_LIMIT     = 500;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_ROUNDS   = 10;
  localparam int TICKS_PER_ROUND = 115;
  localparam int LOCKOUT_SOAK    = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_pin_level = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_click;
  logic               out_hold;
  logic [PHASE_W-1:0] out_phase;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [TICK_W-1:0]  cfg_data = '0;

  // Handshake history from the last rising edge
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // Detector shadow: configuration and tick state
  cfg_t               shadow_cfg;
  logic [PHASE_W-1:0] cur_phase;
  logic [CNT_W-1:0]   since_arm;
  logic [CNT_W-1:0]   since_release;
  logic               last_pin;

  logic    pin_queue[$];
  result_t expected_results[$];
  int      queued_total = 0;
  int      ticks_taken = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      send_gap = 0;
  int      ready_wait = 0;
  bit      gaps_on = 1'b1;

  button_click_hold_detector_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pin_level (in_pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_click    (out_click),
    .out_hold     (out_hold),
    .out_phase    (out_phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow state after reset
  task automatic reset_detector();
    shadow_cfg.debounce_ticks = DEBOUNCE_RST;
    shadow_cfg.hold_ticks     = HOLD_RST;
    shadow_cfg.invert_level   = 1'b0;
    shadow_cfg.edge_arm_mode  = 1'b0;
    cur_phase     = PH_IDLE;
    since_arm     = '0;
    since_release = CNT_MAX;
    last_pin      = 1'b0;
  endtask

  // Register write into the shadow; unknown indexes are dropped
  task automatic apply_write(input logic [CIDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    case (idx)
      CFG_DEBOUNCE: shadow_cfg.debounce_ticks = val;
      CFG_HOLD:     shadow_cfg.hold_ticks = val;
      CFG_INVERT:   shadow_cfg.invert_level = val[0];
      CFG_EDGE:     shadow_cfg.edge_arm_mode = val[0];
      default: ;
    endcase
  endtask

  // One millisecond tick: count, then arm, click and hold checks in order
  function automatic result_t detector_tick(input logic pin);
    result_t r;
    logic    pressed;
    logic    arm_hit;
    r = '0;
    pressed = pin ^ shadow_cfg.invert_level;
    if (since_arm != CNT_MAX) since_arm = since_arm + 1'b1;
    if (since_release != CNT_MAX) since_release = since_release + 1'b1;
    arm_hit = shadow_cfg.edge_arm_mode ? (pin != last_pin) : pressed;
    if (cur_phase == PH_IDLE && arm_hit && since_release > shadow_cfg.debounce_ticks) begin
      cur_phase = PH_DEBOUNCE;
      since_arm = '0;
    end
    if (cur_phase == PH_DEBOUNCE && since_arm > shadow_cfg.debounce_ticks)
      cur_phase = PH_CLICK;
    if (cur_phase == PH_CLICK && !pressed) begin
      r.click = 1'b1;
      since_release = '0;
      cur_phase = PH_IDLE;
    end
    if (cur_phase == PH_CLICK && since_arm > shadow_cfg.hold_ticks)
      cur_phase = PH_HOLD;
    if (cur_phase == PH_HOLD && !pressed) begin
      r.hold = 1'b1;
      since_release = '0;
      cur_phase = PH_IDLE;
    end
    last_pin = pin;
    r.phase = cur_phase;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Monitor: shadow updates, result checks and the watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        expected_results.push_back(detector_tick(in_pin_level));
        ticks_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got click %0b hold %0b phase %0d",
                   $time, out_click, out_hold, out_phase);
        end else begin
          want = expected_results.pop_front();
          check_field("click", want.click, out_click);
          check_field("hold", want.hold, out_hold);
          check_field("phase", want.phase, out_phase);
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Tick request driver with a random gap after each request
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pin_queue.size() != 0) begin
        in_pin_level <= pin_queue.pop_front();
        in_valid <= 1'b1;
        send_gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink with a random stall ahead of each result
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) ready_wait = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (ready_wait > 0) begin
        ready_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_pin(input logic pin);
    pin_queue.push_back(pin);
    queued_total++;
  endtask

  // Raw pin levels, MSB first
  task automatic push_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) push_pin(bits[i]);
  endtask

  // Pressed or released level for n ticks, translated through the polarity
  task automatic push_level(input logic pressed, input int n);
    repeat (n) push_pin(pressed ^ shadow_cfg.invert_level);
  endtask

  task automatic push_bounce(input int n);
    repeat (n) push_pin($urandom_range(0, 1));
  endtask

  // Wait until every tick is taken and every result checked
  task automatic settle();
    while (ticks_taken != queued_total || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int deb;
    int hold;
    int hold_cap;
    int len;
    int round_start;
    logic inv;
    logic edge_mode;

    reset_detector();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Edge mode on the very first tick: high pin counts as a change
    write_reg(CFG_EDGE, 16'd1);
    push_pattern(32'b1101, 4);
    settle();

    // Writes while armed take effect at the next compare; then a hold and a click
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_HOLD, 16'd2);
    write_reg(CFG_EDGE, 16'd0);
    push_pattern(32'b10110, 5);
    settle();

    // Zero debounce and zero hold still need one tick each
    write_reg(CFG_HOLD, 16'd0);
    push_pattern(32'b110, 3);
    settle();

    // Hold shorter than debounce: hold only after the debounce time
    write_reg(CFG_DEBOUNCE, 16'd3);
    write_reg(CFG_HOLD, 16'd1);
    push_pattern(32'b000111110, 9);
    settle();

    // Inverted polarity with masked data, edge arming on the released level,
    // and a write to an unused index
    write_reg(CFG_INVERT, 16'hFFFF);
    write_reg(CFG_EDGE, 16'h0003);
    write_reg(CFG_DEBOUNCE, 16'd1);
    write_reg(CFG_HOLD, 16'hFFFF);
    write_reg(CIDX_W'(4), 16'd0);
    push_pattern(32'b000111, 6);
    settle();

    // Largest debounce: the release lockout keeps a press from arming
    gaps_on = 1'b0;
    write_reg(CFG_INVERT, 16'd0);
    write_reg(CFG_EDGE, 16'd0);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    push_level(1'b0, LOCKOUT_SOAK);
    push_level(1'b1, 2);
    settle();

    // Random rounds: presses of random length with bounce and noise
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      deb = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      case ($urandom_range(0, 5))
        0:       hold = 0;
        1:       hold = 65535;
        default: hold = $urandom_range(0, 40);
      endcase
      inv = $urandom_range(0, 1);
      edge_mode = $urandom_range(0, 1);
      write_reg(CFG_DEBOUNCE, TICK_W'(deb));
      write_reg(CFG_HOLD, TICK_W'(hold));
      write_reg(CFG_INVERT, TICK_W'(($urandom & 32'hFFFE) | inv));
      write_reg(CFG_EDGE, TICK_W'(($urandom & 32'hFFFE) | edge_mode));
      if ($urandom_range(0, 3) == 0)
        write_reg(CIDX_W'($urandom_range(4, 255)), TICK_W'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      hold_cap = (hold > 50) ? 50 : hold;
      round_start = queued_total;
      while (queued_total - round_start < TICKS_PER_ROUND) begin
        if ($urandom_range(0, 7) == 0) begin
          push_bounce($urandom_range(1, 6));
        end else begin
          case ($urandom_range(0, 3))
            0:       len = $urandom_range(1, deb + 1);
            1:       len = deb + $urandom_range(1, 3);
            2:       len = $urandom_range(deb + 1, deb + 1 + hold_cap);
            default: len = ((deb > hold_cap) ? deb : hold_cap) + $urandom_range(1, 4);
          endcase
          if ($urandom_range(0, 2) == 0) push_bounce($urandom_range(1, 3));
          push_level(1'b1, len);
          if ($urandom_range(0, 2) == 0) push_bounce($urandom_range(1, 3));
          push_level(1'b0, $urandom_range(0, deb + 3));
        end
      end
      settle();
    end

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
